// ===== hdl/cfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and defaults for the complex fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package cfa_pkg;

    // default operand part width and fraction bits (Q8.8)
    localparam int DEF_WIDTH = 16;
    localparam int DEF_FRAC  = 8;

    // operation codes
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

endpackage

// ===== hdl/cfa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_front
// Two-stage front end: partial products, then the sums each operation needs.
// ----------------------------------------------------------------------------
module cfa_front #(
    parameter int WIDTH = cfa_pkg::DEF_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  cfa_pkg::action_t          in_action,
    input  logic signed [WIDTH-1:0]   a_real,
    input  logic signed [WIDTH-1:0]   a_imag,
    input  logic signed [WIDTH-1:0]   b_real,
    input  logic signed [WIDTH-1:0]   b_imag,
    output logic                      out_valid,
    output cfa_pkg::action_t          out_action,
    output logic signed [2*WIDTH:0]   sum_r,
    output logic signed [2*WIDTH:0]   sum_i,
    output logic [2*WIDTH-1:0]        den
);

    localparam int PW = 2 * WIDTH;
    localparam int SW = 2 * WIDTH + 1;

    logic                    va_reg;
    cfa_pkg::action_t        act_a_reg;
    logic signed [PW-1:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_dd_reg;
    logic signed [WIDTH:0]   as_r_reg, as_i_reg;
    logic signed [WIDTH:0]   as_r_next, as_i_next;

    logic                    vb_reg;
    cfa_pkg::action_t        act_b_reg;
    logic signed [SW-1:0]    sum_r_reg, sum_i_reg, sum_r_next, sum_i_next;
    logic [PW-1:0]           den_reg;

    // add / subtract part by part
    always_comb
    begin
        if (in_action == cfa_pkg::ACT_SUB)
        begin
            as_r_next = (WIDTH+1)'(a_real) - (WIDTH+1)'(b_real);
            as_i_next = (WIDTH+1)'(a_imag) - (WIDTH+1)'(b_imag);
        end
        else
        begin
            as_r_next = (WIDTH+1)'(a_real) + (WIDTH+1)'(b_real);
            as_i_next = (WIDTH+1)'(a_imag) + (WIDTH+1)'(b_imag);
        end
    end

    // stage A: products and add / subtract sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_a_reg <= in_action;
            p_rr_reg  <= PW'(a_real) * PW'(b_real);
            p_ii_reg  <= PW'(a_imag) * PW'(b_imag);
            p_ri_reg  <= PW'(a_real) * PW'(b_imag);
            p_ir_reg  <= PW'(a_imag) * PW'(b_real);
            p_bb_reg  <= PW'(b_real) * PW'(b_real);
            p_dd_reg  <= PW'(b_imag) * PW'(b_imag);
            as_r_reg  <= as_r_next;
            as_i_reg  <= as_i_next;
        end
    end

    // stage B sums by operation
    always_comb
    begin
        case (act_a_reg)
            cfa_pkg::ACT_MUL:
            begin
                sum_r_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                sum_i_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            cfa_pkg::ACT_DIV:
            begin
                sum_r_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                sum_i_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default:
            begin
                sum_r_next = SW'(as_r_reg);
                sum_i_next = SW'(as_i_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_b_reg <= act_a_reg;
            sum_r_reg <= sum_r_next;
            sum_i_reg <= sum_i_next;
            // squares are non-negative and their sum fits PW bits unsigned
            den_reg   <= PW'(unsigned'(p_bb_reg)) + PW'(unsigned'(p_dd_reg));
        end
    end

    assign out_valid  = vb_reg;
    assign out_action = act_b_reg;
    assign sum_r      = sum_r_reg;
    assign sum_i      = sum_i_reg;
    assign den        = den_reg;

endmodule

// ===== hdl/cfa_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_div_step
// One restoring-division stage: one quotient bit for each of two lanes.
// ----------------------------------------------------------------------------
module cfa_div_step #(
    parameter int  NW = 41,
    parameter int  DW = 33,
    parameter type side_t = logic
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  side_t          in_side,
    input  logic [DW-2:0]  in_den,
    input  logic [NW-1:0]  in_qr,
    input  logic [DW-1:0]  in_rr,
    input  logic [NW-1:0]  in_qi,
    input  logic [DW-1:0]  in_ri,
    output logic           out_valid,
    output side_t          out_side,
    output logic [DW-2:0]  out_den,
    output logic [NW-1:0]  out_qr,
    output logic [DW-1:0]  out_rr,
    output logic [NW-1:0]  out_qi,
    output logic [DW-1:0]  out_ri
);

    logic          valid_reg;
    side_t         side_reg;
    logic [DW-2:0] den_reg;
    logic [NW-1:0] qr_reg, qi_reg, qr_next, qi_next;
    logic [DW-1:0] rr_reg, ri_reg, rr_next, ri_next;
    logic [DW-1:0] sh_r, sh_i;
    logic          ge_r, ge_i;

    // shift in next numerator bit, subtract divisor when it fits
    always_comb
    begin
        sh_r    = {in_rr[DW-2:0], in_qr[NW-1]};
        sh_i    = {in_ri[DW-2:0], in_qi[NW-1]};
        ge_r    = sh_r >= {1'b0, in_den};
        ge_i    = sh_i >= {1'b0, in_den};
        rr_next = ge_r ? (sh_r - {1'b0, in_den}) : sh_r;
        ri_next = ge_i ? (sh_i - {1'b0, in_den}) : sh_i;
        qr_next = {in_qr[NW-2:0], ge_r};
        qi_next = {in_qi[NW-2:0], ge_i};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            den_reg  <= in_den;
            qr_reg   <= qr_next;
            qi_reg   <= qi_next;
            rr_reg   <= rr_next;
            ri_reg   <= ri_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_den   = den_reg;
    assign out_qr    = qr_reg;
    assign out_rr    = rr_reg;
    assign out_qi    = qi_reg;
    assign out_ri    = ri_reg;

endmodule

// ===== hdl/complex_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Pipelined complex add / subtract / multiply / divide on signed fixed point.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the output is free or being read,
// and one result word leaves for each, in order. A word passes two front
// stages for products and sums, one restoring-division stage per quotient bit
// (every operation travels the same chain), and the output register. The
// whole pipeline advances together; it holds while a result waits unread.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu #(
    parameter int WIDTH = cfa_pkg::DEF_WIDTH,
    parameter int FRAC  = cfa_pkg::DEF_FRAC
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // action, a_real, a_imag, b_real, b_imag (low bit up), zero padded
    input  logic [((4*WIDTH+2+7)/8)*8-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // res_real, res_imag (low bit up), zero padded
    output logic [((2*WIDTH+7)/8)*8-1:0]          m_tdata,
    // saturated, divide_by_zero (low bit up)
    output logic [1:0]                            m_tuser
);

    localparam int SW    = 2 * WIDTH + 1;
    localparam int NW    = SW + FRAC;
    localparam int DW    = 2 * WIDTH + 1;
    localparam int OUT_W = ((2 * WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic                    is_div;
        logic                    dbz;
        logic                    neg_r;
        logic                    neg_i;
        logic                    sat;
        logic signed [WIDTH-1:0] res_r;
        logic signed [WIDTH-1:0] res_i;
    } side_t;

    localparam logic signed [SW-1:0] S_MAX = SW'((64'd1 << (WIDTH-1)) - 64'd1);
    localparam logic signed [SW-1:0] S_MIN = -SW'(64'd1 << (WIDTH-1));
    localparam logic [NW-1:0] Q_POS = NW'((64'd1 << (WIDTH-1)) - 64'd1);
    localparam logic [NW-1:0] Q_NEG = NW'(64'd1 << (WIDTH-1));

    logic                   en;
    logic                   f_valid;
    cfa_pkg::action_t       f_action;
    logic signed [SW-1:0]   f_sum_r, f_sum_i;
    logic [2*WIDTH-1:0]     f_den;

    logic m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0] m_tuser_reg, m_tuser_next;

    // global advance: output slot free or being taken
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cfa_front #(.WIDTH(WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_action  (cfa_pkg::action_t'(s_tdata[1:0])),
        .a_real     (s_tdata[2+WIDTH-1:2]),
        .a_imag     (s_tdata[2+2*WIDTH-1:2+WIDTH]),
        .b_real     (s_tdata[2+3*WIDTH-1:2+2*WIDTH]),
        .b_imag     (s_tdata[2+4*WIDTH-1:2+3*WIDTH]),
        .out_valid  (f_valid),
        .out_action (f_action),
        .sum_r      (f_sum_r),
        .sum_i      (f_sum_i),
        .den        (f_den)
    );

    // non-divide results, divider operands
    logic signed [SW-1:0] v_r, v_i;
    side_t                side0;
    logic [NW-1:0]        num_r0, num_i0;
    logic [SW-1:0]        mag_r, mag_i;

    always_comb
    begin
        if (f_action == cfa_pkg::ACT_MUL)
        begin
            v_r = f_sum_r >>> FRAC;
            v_i = f_sum_i >>> FRAC;
        end
        else
        begin
            v_r = f_sum_r;
            v_i = f_sum_i;
        end
        side0.is_div = (f_action == cfa_pkg::ACT_DIV);
        side0.dbz    = (f_action == cfa_pkg::ACT_DIV) && (f_den == '0);
        side0.neg_r  = f_sum_r[SW-1];
        side0.neg_i  = f_sum_i[SW-1];
        side0.sat    = (v_r > S_MAX) || (v_r < S_MIN) || (v_i > S_MAX) || (v_i < S_MIN);
        side0.res_r  = (v_r > S_MAX) ? WIDTH'(S_MAX) :
                       (v_r < S_MIN) ? WIDTH'(S_MIN) : WIDTH'(v_r);
        side0.res_i  = (v_i > S_MAX) ? WIDTH'(S_MAX) :
                       (v_i < S_MIN) ? WIDTH'(S_MIN) : WIDTH'(v_i);
        mag_r  = f_sum_r[SW-1] ? SW'(-f_sum_r) : SW'(f_sum_r);
        mag_i  = f_sum_i[SW-1] ? SW'(-f_sum_i) : SW'(f_sum_i);
        num_r0 = NW'(mag_r) << FRAC;
        num_i0 = NW'(mag_i) << FRAC;
    end

    // division chain, one quotient bit per stage
    logic          d_valid [0:NW];
    side_t         d_side  [0:NW];
    logic [DW-2:0] d_den   [0:NW];
    logic [NW-1:0] d_qr    [0:NW];
    logic [NW-1:0] d_qi    [0:NW];
    logic [DW-1:0] d_rr    [0:NW];
    logic [DW-1:0] d_ri    [0:NW];

    assign d_valid[0] = f_valid;
    assign d_side[0]  = side0;
    assign d_den[0]   = f_den;
    assign d_qr[0]    = num_r0;
    assign d_qi[0]    = num_i0;
    assign d_rr[0]    = '0;
    assign d_ri[0]    = '0;

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        cfa_div_step #(.NW(NW), .DW(DW), .side_t(side_t)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d_valid[k]),
            .in_side   (d_side[k]),
            .in_den    (d_den[k]),
            .in_qr     (d_qr[k]),
            .in_rr     (d_rr[k]),
            .in_qi     (d_qi[k]),
            .in_ri     (d_ri[k]),
            .out_valid (d_valid[k+1]),
            .out_side  (d_side[k+1]),
            .out_den   (d_den[k+1]),
            .out_qr    (d_qr[k+1]),
            .out_rr    (d_rr[k+1]),
            .out_qi    (d_qi[k+1]),
            .out_ri    (d_ri[k+1])
        );
    end

    // final selection and quotient clipping
    side_t                 sf;
    logic [NW-1:0]         qr, qi;
    logic signed [WIDTH-1:0] dr, di;
    logic                  sr, si;

    always_comb
    begin
        sf = d_side[NW];
        qr = d_qr[NW];
        qi = d_qi[NW];
        if (sf.neg_r)
        begin
            sr = qr > Q_NEG;
            dr = sr ? WIDTH'(S_MIN) : WIDTH'(-qr);
        end
        else
        begin
            sr = qr > Q_POS;
            dr = sr ? WIDTH'(S_MAX) : WIDTH'(qr);
        end
        if (sf.neg_i)
        begin
            si = qi > Q_NEG;
            di = si ? WIDTH'(S_MIN) : WIDTH'(-qi);
        end
        else
        begin
            si = qi > Q_POS;
            di = si ? WIDTH'(S_MAX) : WIDTH'(qi);
        end

        m_tdata_next = '0;
        if (sf.dbz)
        begin
            m_tuser_next = 2'b10;
        end
        else if (sf.is_div)
        begin
            m_tdata_next[2*WIDTH-1:0] = {di, dr};
            m_tuser_next = {1'b0, sr | si};
        end
        else
        begin
            m_tdata_next[2*WIDTH-1:0] = {sf.res_i, sf.res_r};
            m_tuser_next = {1'b0, sf.sat};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= d_valid[NW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/cfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks for the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cfa_checker #(
    parameter int WIDTH = cfa_pkg::DEF_WIDTH
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*WIDTH+7)/8)*8-1:0]         m_tdata,
    input logic [1:0]                           m_tuser
);

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // zero divisor gives zero parts and no saturation
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("divide by zero result not clean");

    // input stalls exactly when the output is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output backpressure");

    // nothing appears out of an empty, unblocked pipe right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result word right after reset");

endmodule

bind complex_fixed_point_alu cfa_checker #(.WIDTH(WIDTH)) u_cfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/complex_fixed_point_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fixed_point_alu_test
// Self-checking stream test of the complex fixed-point ALU: directed corner
// words, then random words under three idling mixes and one long output hold.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu_test;

    localparam int W  = cfa_pkg::DEF_WIDTH;
    localparam int FR = cfa_pkg::DEF_FRAC;
    localparam int IW = ((4*W+2+7)/8)*8;
    localparam int OW = ((2*W+7)/8)*8;
    localparam int LATENCY = 2*W+FR+4;
    localparam int N_RANDOM = 1700;

    typedef struct packed {
        logic [W-1:0]     b_imag;
        logic [W-1:0]     b_real;
        logic [W-1:0]     a_imag;
        logic [W-1:0]     a_real;
        cfa_pkg::action_t action;
    } operand_word_t;

    typedef struct {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         sat;
        logic         dbz;
    } alu_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [IW-1:0]  s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [OW-1:0]  m_tdata;
    logic [1:0]     m_tuser;

    operand_word_t  pending_words[$];
    alu_result_t    expected_results[$];
    int             send_idle_pct = 17;
    int             recv_idle_pct = 86;
    int             hold_cycles = 0;
    int             errors = 0;
    int             n_checked = 0;
    int             n_sat = 0;
    int             n_dbz = 0;
    int             wi;
    bit             stim_done = 1'b0;

    complex_fixed_point_alu uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // clip a wide signed value into the part range
    function automatic logic [W-1:0] clip_part(input logic signed [127:0] v,
                                               inout logic sat);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (W-1)) - 1;
        lo = -(128'sd1 <<< (W-1));
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[W-1:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // quotient truncated toward zero
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic [127:0] mag;
        mag = (n < 0 ? -n : n) / d;
        return (n < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic alu_result_t compute_result(input operand_word_t w);
        alu_result_t r;
        logic signed [127:0] ar, ai, br, bi, den, pr, pi;
        ar = $signed(w.a_real);
        ai = $signed(w.a_imag);
        br = $signed(w.b_real);
        bi = $signed(w.b_imag);
        r.sat = 1'b0;
        r.dbz = 1'b0;
        r.re = '0;
        r.im = '0;
        case (w.action)
            cfa_pkg::ACT_ADD:
            begin
                r.re = clip_part(ar + br, r.sat);
                r.im = clip_part(ai + bi, r.sat);
            end
            cfa_pkg::ACT_SUB:
            begin
                r.re = clip_part(ar - br, r.sat);
                r.im = clip_part(ai - bi, r.sat);
            end
            cfa_pkg::ACT_MUL:
            begin
                // arithmetic shift floors toward minus infinity
                r.re = clip_part((ar*br - ai*bi) >>> FR, r.sat);
                r.im = clip_part((ar*bi + ai*br) >>> FR, r.sat);
            end
            default:
            begin
                den = br*br + bi*bi;
                if (den == 0)
                    r.dbz = 1'b1;
                else
                begin
                    pr = (ar*br + ai*bi) <<< FR;
                    pi = (ai*br - ar*bi) <<< FR;
                    r.re = clip_part(div_trunc(pr, den), r.sat);
                    r.im = clip_part(div_trunc(pi, den), r.sat);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(W-1){1'b1}}};
            1: return {1'b1, {(W-1){1'b0}}};
            2: return W'($signed($urandom_range(0, 1024)) - 512);
            3: return '0;
            default: return W'($urandom);
        endcase
    endfunction

    task automatic push_word(input cfa_pkg::action_t act, input logic [W-1:0] a_re,
                             input logic [W-1:0] a_im, input logic [W-1:0] b_re,
                             input logic [W-1:0] b_im);
        operand_word_t w;
        w.action = act;
        w.a_real = a_re;
        w.a_imag = a_im;
        w.b_real = b_re;
        w.b_imag = b_im;
        pending_words.push_back(w);
    endtask

    // driver: one word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata <= IW'(pending_words.pop_front());
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // predict at input acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(compute_result(operand_word_t'(s_tdata[4*W+1:0])));
    end

    // receiver ready, with a long hold-off stretch on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        alu_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word re=%h im=%h", $time,
                         m_tdata[W-1:0], m_tdata[2*W-1:W]);
                errors = errors + 1;
            end
            else
            begin
                e = expected_results.pop_front();
                n_checked = n_checked + 1;
                if (e.sat) n_sat = n_sat + 1;
                if (e.dbz) n_dbz = n_dbz + 1;
                if (m_tdata[W-1:0] !== e.re)
                begin
                    $display("%0t: res_real expected %h actual %h", $time, e.re,
                             m_tdata[W-1:0]);
                    errors = errors + 1;
                end
                if (m_tdata[2*W-1:W] !== e.im)
                begin
                    $display("%0t: res_imag expected %h actual %h", $time, e.im,
                             m_tdata[2*W-1:W]);
                    errors = errors + 1;
                end
                if (m_tuser[0] !== e.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, e.sat,
                             m_tuser[0]);
                    errors = errors + 1;
                end
                if (m_tuser[1] !== e.dbz)
                begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time, e.dbz,
                             m_tuser[1]);
                    errors = errors + 1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [W-1:0] pmax, nmin, one;
        pmax = {1'b0, {(W-1){1'b1}}};
        nmin = {1'b1, {(W-1){1'b0}}};
        one  = W'(1 << FR);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        push_word(cfa_pkg::ACT_ADD, pmax, nmin, pmax, nmin);
        push_word(cfa_pkg::ACT_ADD, 16'h0001, 16'hffff, 16'h0002, 16'h0003);
        push_word(cfa_pkg::ACT_SUB, nmin, pmax, pmax, nmin);
        push_word(cfa_pkg::ACT_SUB, 16'h1234, 16'h0000, 16'h1234, 16'h0000);
        push_word(cfa_pkg::ACT_MUL, nmin, nmin, nmin, nmin);
        push_word(cfa_pkg::ACT_MUL, pmax, pmax, pmax, nmin);
        push_word(cfa_pkg::ACT_MUL, one, one, one, nmin);
        push_word(cfa_pkg::ACT_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
        push_word(cfa_pkg::ACT_MUL, 16'h0000, 16'h0000, pmax, pmax);
        push_word(cfa_pkg::ACT_DIV, one, one, 16'h0000, 16'h0000);
        push_word(cfa_pkg::ACT_DIV, pmax, nmin, 16'h0000, 16'h0000);
        push_word(cfa_pkg::ACT_DIV, one, 16'h0000, one, 16'h0000);
        push_word(cfa_pkg::ACT_DIV, pmax, pmax, 16'h0001, 16'h0000);
        push_word(cfa_pkg::ACT_DIV, nmin, nmin, 16'h0000, 16'hffff);
        push_word(cfa_pkg::ACT_DIV, nmin, nmin, nmin, nmin);
        push_word(cfa_pkg::ACT_DIV, 16'hffff, 16'h0001, pmax, pmax);
        push_word(cfa_pkg::ACT_DIV, 16'h0003, 16'hfffd, 16'h0200, 16'h0000);
        push_word(cfa_pkg::ACT_DIV, one, 16'h0000, one, one);
        push_word(cfa_pkg::ACT_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_word(cfa_pkg::ACT_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        // three idling mixes over the random words
        for (wi = 0; wi < N_RANDOM; wi++)
        begin
            if (wi == N_RANDOM/3)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 17;
            end
            if (wi == 2*N_RANDOM/3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // let the pipeline fill against a stalled output
                hold_cycles = 300;
            end
            push_word(cfa_pkg::action_t'($urandom_range(0, 3)), rand_part(), rand_part(),
                      rand_part(), rand_part());
            while (pending_words.size() > 8) @(posedge clk);
        end
        while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
        while (expected_results.size() > 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        $display("Checked %0d result words over add/sub/mul/div, %0d saturated, %0d zero divisor.",
                 n_checked, n_sat, n_dbz);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
